// ----- hw/rtl/bev_pkg.sv -----
package bev_pkg;

  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned BUTTON_COUNT_DEF = 16;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 4;

  localparam logic [FIELD_W-1:0] POLARITY_RST = 16'd0;
  localparam logic [FIELD_W-1:0] LONG_RST     = 16'd100;
  localparam logic [FIELD_W-1:0] REPEAT_RST   = 16'd50;

  typedef enum logic [1:0] {
    REG_POLARITY = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_t;

  typedef logic [FIELD_W-1:0] btn_vec_t;

  typedef struct packed {
    btn_vec_t polarity;
    btn_vec_t long_ticks;
    btn_vec_t repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic     vld;
    btn_vec_t raw;
  } stage_t;

endpackage

// ----- hw/rtl/bev_in_if.sv -----
interface bev_in_if
  import bev_pkg::*;
();
  logic     valid;
  logic     ready;
  btn_vec_t btn_sample;

  modport source (output valid, output btn_sample, input ready);
  modport sink (input valid, input btn_sample, output ready);
endinterface

// ----- hw/rtl/bev_out_if.sv -----
interface bev_out_if
  import bev_pkg::*;
();
  logic     valid;
  logic     ready;
  btn_vec_t pressed_now;
  btn_vec_t press_edge;
  btn_vec_t toggle_bits;
  btn_vec_t repeat_press;
  btn_vec_t release_edge;
  btn_vec_t short_release;
  btn_vec_t long_release;
  btn_vec_t hold_event;

  modport source (
    output valid, input ready,
    output pressed_now, output press_edge, output toggle_bits, output repeat_press,
    output release_edge, output short_release, output long_release, output hold_event
  );
  modport sink (
    input valid, output ready,
    input pressed_now, input press_edge, input toggle_bits, input repeat_press,
    input release_edge, input short_release, input long_release, input hold_event
  );
endinterface

// ----- hw/rtl/bev_cfg_regs.sv -----
module bev_cfg_regs
  import bev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;
  cfg_t     cfg_r;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polarity     <= POLARITY_RST;
      cfg_r.long_ticks   <= LONG_RST;
      cfg_r.repeat_ticks <= REPEAT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_POLARITY: cfg_r.polarity     <= pwdata[FIELD_W-1:0];
        REG_LONG:     cfg_r.long_ticks   <= pwdata[FIELD_W-1:0];
        REG_REPEAT:   cfg_r.repeat_ticks <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLARITY: prdata = APB_DATA_W'(cfg_r.polarity);
      REG_LONG:     prdata = APB_DATA_W'(cfg_r.long_ticks);
      REG_REPEAT:   prdata = APB_DATA_W'(cfg_r.repeat_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/bev_in_reg.sv -----
module bev_in_reg
  import bev_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  bev_in_if.sink   in_ch,
  input  logic     out_free,
  output stage_t   stage
);

  logic     vld_r;
  btn_vec_t raw_r;

  assign in_ch.ready = !vld_r || out_free;
  assign stage.vld   = vld_r;
  assign stage.raw   = raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      raw_r <= in_ch.btn_sample;
    end
  end

endmodule

// ----- hw/rtl/bev_event_unit.sv -----
module bev_event_unit
  import bev_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  stage_t   stage,
  output logic     out_free,
  bev_out_if.source out_ch
);

  localparam int unsigned NB = (BUTTON_COUNT < FIELD_W) ? BUTTON_COUNT : FIELD_W;

  logic [NB-1:0]      prev_r, toggle_r;
  btn_vec_t           timer_r;
  logic               out_vld_r;
  logic [NB-1:0]      pressed_r, press_r, toggle_out_r, repeat_r;
  logic [NB-1:0]      release_r, short_r, long_r, hold_r;

  btn_vec_t           cur_full;
  logic [NB-1:0]      cur, down, up, toggle_nxt, repeat_nxt;
  logic               changed, was_short, at_cap, rep, hold, adv;
  btn_vec_t           timer_nxt;
  logic [FIELD_W:0]   cap;

  assign out_free = !out_vld_r || out_ch.ready;
  assign adv      = stage.vld && out_free;

  always_comb begin
    cur_full   = stage.raw ^ cfg.polarity;
    cur        = cur_full[NB-1:0];
    changed    = cur != prev_r;
    was_short  = timer_r < cfg.long_ticks;
    // cap is long+1, pinned at all-ones
    cap        = (&cfg.long_ticks) ? {1'b0, cfg.long_ticks}
                                   : {1'b0, cfg.long_ticks} + 1'b1;
    at_cap     = {1'b0, timer_r} == cap;
    if (changed) begin
      timer_nxt = '0;
    end else if (at_cap) begin
      timer_nxt = timer_r;
    end else begin
      timer_nxt = timer_r + 1'b1;
    end
    rep        = !changed && (timer_nxt >= cfg.repeat_ticks);
    hold       = !changed && (timer_nxt == cfg.long_ticks);
    down       = cur & ~prev_r;
    up         = ~cur & prev_r;
    toggle_nxt = toggle_r ^ down;
    repeat_nxt = cur & (~prev_r | {NB{rep}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      toggle_r  <= '0;
      timer_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      prev_r    <= cur;
      toggle_r  <= toggle_nxt;
      timer_r   <= timer_nxt;
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pressed_r    <= cur;
      press_r      <= down;
      toggle_out_r <= toggle_nxt;
      repeat_r     <= repeat_nxt;
      release_r    <= up;
      short_r      <= (changed && was_short) ? up : '0;
      long_r       <= (changed && !was_short) ? up : '0;
      hold_r       <= hold ? cur : '0;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.pressed_now   = btn_vec_t'(pressed_r);
  assign out_ch.press_edge    = btn_vec_t'(press_r);
  assign out_ch.toggle_bits   = btn_vec_t'(toggle_out_r);
  assign out_ch.repeat_press  = btn_vec_t'(repeat_r);
  assign out_ch.release_edge  = btn_vec_t'(release_r);
  assign out_ch.short_release = btn_vec_t'(short_r);
  assign out_ch.long_release  = btn_vec_t'(long_r);
  assign out_ch.hold_event    = btn_vec_t'(hold_r);

endmodule

// ----- hw/rtl/button_event_generator.sv -----
// Button event generator: one request per scan tick, a raw button sample in, eight event
// vectors out. Takes a new request every clock cycle unless the result side stalls; a
// result is presented after its request has passed the input register and then the result
// register. Back-pressure on the result side stalls the input side through a combinational
// ready path. The single shared steady timer, previous vector and toggle bits advance as
// each request moves into the result register.
// Registers (APB, 32-bit, word aligned): 0x0 polarity_mask, 0x4 long_press_ticks,
// 0x8 repeat_start_ticks; write them only while the block is idle.
module button_event_generator
  import bev_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bev_in_if.sink                in_ch,
  bev_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   out_free;

  bev_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bev_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .stage    (stage)
  );

  bev_event_unit #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_evt (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .stage    (stage),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ----- hw/rtl/bev_checker.sv -----
module bev_checker
  import bev_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input btn_vec_t pressed_now,
  input btn_vec_t press_edge,
  input btn_vec_t repeat_press,
  input btn_vec_t release_edge,
  input btn_vec_t short_release,
  input btn_vec_t long_release
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(press_edge) && $stable(release_edge))
    else $error("stalled result changed");

  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((press_edge & release_edge) == '0) && ((press_edge & ~pressed_now) == '0))
    else $error("press/release edges inconsistent");

  a_release_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((short_release & long_release) == '0)
                  && ((short_release | long_release) == release_edge))
    else $error("release not split into exactly one of short/long");

  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((press_edge & ~repeat_press) == '0) && ((repeat_press & ~pressed_now) == '0))
    else $error("repeat vector inconsistent");

endmodule

bind button_event_generator bev_checker u_bev_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pressed_now   (out_ch.pressed_now),
  .press_edge    (out_ch.press_edge),
  .repeat_press  (out_ch.repeat_press),
  .release_edge  (out_ch.release_edge),
  .short_release (out_ch.short_release),
  .long_release  (out_ch.long_release)
);
